// ===== src/hfv_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the
// heartbeat failure voter. No dependencies; every other file imports it.
package hfv_pkg;

  localparam int MAX_NODES  = 16;
  localparam int COUNT_BITS = 8;
  localparam int IDX_W      = $clog2(MAX_NODES);
  localparam int NCNT_W     = $clog2(MAX_NODES + 1);

  // Field widths fixed by the message format.
  localparam int ID_W    = 4;
  localparam int KIND_W  = 3;
  localparam int OP_W    = 3;
  localparam int VOTES_W = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int LIMIT_W    = 7;
  localparam int NCFG_W     = 5;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_REQ  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_YES  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_NO   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ERR  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NONE = 3'd4;

  // Message opcodes.
  localparam logic [OP_W-1:0] OP_HEARTBEAT  = 3'd0;
  localparam logic [OP_W-1:0] OP_VOTE_REQ   = 3'd1;
  localparam logic [OP_W-1:0] OP_VOTE_YES   = 3'd2;
  localparam logic [OP_W-1:0] OP_VOTE_NO    = 3'd3;
  localparam logic [OP_W-1:0] OP_KILL_ACK   = 3'd4;
  localparam logic [OP_W-1:0] OP_KILL_ABORT = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MY_ID      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIMIT = 2'd2;

  // Configuration reset values.
  localparam logic [ID_W-1:0]    MY_ID_RST      = 4'd0;
  localparam logic [NCFG_W-1:0]  NODE_COUNT_RST = 5'd16;
  localparam logic [LIMIT_W-1:0] MISS_LIMIT_RST = 7'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;       // latch the input transaction
    logic             live_step;  // count live entry at idx
    logic             walk_step;  // age entry at idx, maybe request a vote
    logic             finish;     // clear own entry, flush last tick result
    logic             msg_exec;   // act on the latched message
    logic [IDX_W-1:0] idx;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [NCNT_W-1:0] act_n;     // min(node_count, MAX_NODES)
  } ctl_sts_t;

endpackage

// ===== src/hfv_ctrl.sv =====
// Sequencing state machine for the heartbeat failure voter.
// Depends on hfv_pkg; drives hfv_datapath through ctl_cmd_t.
module hfv_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_command,
  input  hfv_pkg::ctl_sts_t sts,
  output hfv_pkg::ctl_cmd_t cmd,
  output logic              busy
);
  import hfv_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MSG  = 5'b00010,
    S_LIVE = 5'b00100,
    S_WALK = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             last_idx;

  assign last_idx = ({1'b0, idx_r} == (sts.act_n - NCNT_W'(1)));

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.idx   = idx_r;
    busy      = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          idx_nxt  = '0;
          if (in_command) begin
            state_nxt = S_MSG;
          end else if (sts.act_n == '0) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_LIVE;
          end
        end
      end
      S_MSG: begin
        cmd.msg_exec = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_LIVE: begin
        cmd.live_step = 1'b1;
        if (last_idx) begin
          idx_nxt   = '0;
          state_nxt = S_WALK;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (last_idx) begin
          state_nxt = S_FIN;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

`ifndef SYNTHESIS
  a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start) |=> (state_r != S_IDLE))
    else $error("accepted transaction did not leave idle");

  a_msg_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MSG) |=> (state_r == S_IDLE))
    else $error("message execution took more than one cycle");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK || state_r == S_LIVE) |-> ({1'b0, idx_r} < sts.act_n))
    else $error("entry walk beyond active node count");
`endif

endmodule

// ===== src/hfv_datapath.sv =====
// Node table, configuration registers and result register of the
// heartbeat failure voter. Depends on hfv_pkg; commanded by hfv_ctrl.
module hfv_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hfv_pkg::ctl_cmd_t           cmd,
  output hfv_pkg::ctl_sts_t           sts,
  input  logic                        cfg_we,
  input  logic [hfv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hfv_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [hfv_pkg::OP_W-1:0]    in_opcode,
  input  logic [hfv_pkg::ID_W-1:0]    in_source_id,
  input  logic [hfv_pkg::ID_W-1:0]    in_subject_id,
  output logic                        out_strobe,
  output logic [hfv_pkg::KIND_W-1:0]  out_kind,
  output logic [hfv_pkg::ID_W-1:0]    out_node_id,
  output logic [hfv_pkg::VOTES_W-1:0] out_votes_needed,
  output logic                        out_last
);
  import hfv_pkg::*;

  localparam int CMP_W = ((COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W) + 1;
  localparam logic signed [COUNT_BITS-1:0] CNT_UNMON = '1;
  localparam logic signed [COUNT_BITS-1:0] CNT_ZERO  = '0;
  localparam logic signed [COUNT_BITS-1:0] CNT_MAX   = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic signed [CMP_W-1:0]      ONE_S     = CMP_W'(1);
  localparam logic [NCNT_W-1:0]            MAX_N     = NCNT_W'(MAX_NODES);

  // Configuration.
  logic [ID_W-1:0]    my_id_r;
  logic [NCFG_W-1:0]  node_count_r;
  logic [LIMIT_W-1:0] miss_limit_r;

  // Node table.
  logic signed [COUNT_BITS-1:0] cnt_r [MAX_NODES];
  logic [MAX_NODES-1:0]         tp_r;
  logic [MAX_NODES-1:0]         coord_r;

  // Latched transaction.
  logic [OP_W-1:0] op_r;
  logic [ID_W-1:0] src_r;
  logic [ID_W-1:0] subj_r;

  // Tick bookkeeping.
  logic [NCNT_W-1:0] live_r;
  logic              pend_v_r;
  logic [IDX_W-1:0]  pend_node_r;

  // Result register.
  logic                out_strobe_r, out_strobe_nxt;
  logic [KIND_W-1:0]   out_kind_r, out_kind_nxt;
  logic [ID_W-1:0]     out_node_r, out_node_nxt;
  logic [VOTES_W-1:0]  out_votes_r, out_votes_nxt;
  logic                out_last_r, out_last_nxt;

  logic [NCNT_W-1:0]            act_n;
  logic [IDX_W-1:0]             rd_idx;
  logic signed [COUNT_BITS-1:0] rd_cnt, cnt_inc;
  logic                         rd_mon, rd_tp, rd_coord;
  logic signed [CMP_W-1:0]      c_s, inc_s, lim_s, lim_m1_s;
  logic                         hit, subj_in, src_in, op_known, vote_ok, vote_yes;
  logic [KIND_W-1:0]            msg_kind;
  logic [VOTES_W-1:0]           need;

  assign act_n     = (node_count_r < MAX_N) ? node_count_r : MAX_N;
  assign sts.act_n = act_n;

  // Single read port into the table: the subject for messages, the walk
  // index otherwise.
  assign rd_idx   = cmd.msg_exec ? subj_r : cmd.idx;
  assign rd_cnt   = cnt_r[rd_idx];
  assign rd_mon   = !rd_cnt[COUNT_BITS-1];
  assign rd_tp    = tp_r[rd_idx];
  assign rd_coord = coord_r[rd_idx];
  assign cnt_inc  = (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + CNT_ZERO + COUNT_BITS'(1);

  assign c_s      = CMP_W'(rd_cnt);
  assign inc_s    = CMP_W'(cnt_inc);
  assign lim_s    = $signed(CMP_W'(miss_limit_r));
  assign lim_m1_s = lim_s - ONE_S;

  assign hit      = rd_mon && (inc_s >= lim_s) && !rd_tp;
  assign need     = VOTES_W'(live_r >> 1);

  assign subj_in  = ({1'b0, subj_r} < act_n);
  assign src_in   = ({1'b0, src_r} < act_n);
  assign op_known = (op_r <= OP_KILL_ABORT);
  assign vote_ok  = !rd_coord || (src_r <= my_id_r);
  assign vote_yes = (c_s >= lim_m1_s) || (!rd_coord && !rd_mon);

  always_comb begin
    msg_kind = KIND_NONE;
    case (op_r) inside
      OP_VOTE_REQ: begin
        if (subj_in && vote_ok) begin
          msg_kind = vote_yes ? KIND_YES : KIND_NO;
        end
      end
      OP_HEARTBEAT, OP_VOTE_YES, OP_VOTE_NO, OP_KILL_ACK, OP_KILL_ABORT: begin
        msg_kind = KIND_NONE;
      end
      default: begin
        msg_kind = KIND_ERR;
      end
    endcase
  end

  // Tick requests are held back one slot so the final one can carry last.
  always_comb begin
    out_strobe_nxt = 1'b0;
    out_kind_nxt   = KIND_NONE;
    out_node_nxt   = '0;
    out_votes_nxt  = '0;
    out_last_nxt   = 1'b0;
    if (cmd.msg_exec) begin
      out_strobe_nxt = 1'b1;
      out_kind_nxt   = msg_kind;
      out_node_nxt   = subj_r;
      out_last_nxt   = 1'b1;
    end else if (cmd.walk_step && hit && pend_v_r) begin
      out_strobe_nxt = 1'b1;
      out_kind_nxt   = KIND_REQ;
      out_node_nxt   = ID_W'(pend_node_r);
      out_votes_nxt  = need;
    end else if (cmd.finish) begin
      out_strobe_nxt = 1'b1;
      out_last_nxt   = 1'b1;
      if (pend_v_r) begin
        out_kind_nxt  = KIND_REQ;
        out_node_nxt  = ID_W'(pend_node_r);
        out_votes_nxt = need;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      my_id_r      <= MY_ID_RST;
      node_count_r <= NODE_COUNT_RST;
      miss_limit_r <= MISS_LIMIT_RST;
      for (int i = 0; i < MAX_NODES; i++) begin
        cnt_r[i] <= (IDX_W'(i) == IDX_W'(MY_ID_RST)) ? CNT_ZERO : CNT_UNMON;
      end
      tp_r         <= '0;
      coord_r      <= '0;
      pend_v_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= out_strobe_nxt;

      if (cmd.load) begin
        pend_v_r <= 1'b0;
      end

      if (cmd.walk_step && rd_mon) begin
        cnt_r[cmd.idx] <= cnt_inc;
      end
      if (cmd.walk_step && hit) begin
        coord_r[cmd.idx] <= 1'b1;
        pend_v_r         <= 1'b1;
      end

      if (cmd.msg_exec) begin
        if (subj_in) begin
          if (op_r == OP_VOTE_REQ && vote_ok) begin
            tp_r[subj_r]    <= 1'b1;
            coord_r[subj_r] <= 1'b0;
          end
          if (op_r == OP_KILL_ACK) begin
            tp_r[subj_r] <= 1'b0;
            // A sender that is its own subject ends cleared below.
            if (src_r != subj_r) begin
              cnt_r[subj_r] <= CNT_UNMON;
            end
          end
          if (op_r == OP_KILL_ABORT) begin
            tp_r[subj_r] <= 1'b0;
          end
        end
        // Sender clear lands after the subject update.
        if (op_known && src_in) begin
          cnt_r[src_r] <= CNT_ZERO;
        end
      end

      if (cmd.finish) begin
        cnt_r[my_id_r] <= CNT_ZERO;
      end

      if (cfg_we) begin
        if (cfg_index == CFG_MY_ID) begin
          my_id_r                   <= cfg_data[ID_W-1:0];
          cnt_r[cfg_data[ID_W-1:0]] <= CNT_ZERO;
        end
        if (cfg_index == CFG_NODE_COUNT) begin
          node_count_r <= cfg_data[NCFG_W-1:0];
        end
        if (cfg_index == CFG_MISS_LIMIT) begin
          miss_limit_r <= cfg_data[LIMIT_W-1:0];
        end
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_opcode;
      src_r  <= in_source_id;
      subj_r <= in_subject_id;
      live_r <= '0;
    end
    if (cmd.live_step && rd_mon) begin
      live_r <= live_r + NCNT_W'(1);
    end
    if (cmd.walk_step && hit) begin
      pend_node_r <= cmd.idx;
    end
    out_kind_r  <= out_kind_nxt;
    out_node_r  <= out_node_nxt;
    out_votes_r <= out_votes_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_strobe       = out_strobe_r;
  assign out_kind         = out_kind_r;
  assign out_node_id      = out_node_r;
  assign out_votes_needed = out_votes_r;
  assign out_last         = out_last_r;

`ifndef SYNTHESIS
  a_only_requests_continue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_kind_r != KIND_REQ) |-> out_last_r)
    else $error("non-request result without last");

  a_votes_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> (out_votes_r <= VOTES_W'(MAX_NODES / 2)))
    else $error("votes_needed above half the group");

  a_finish_flushes: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (out_strobe_r && out_last_r))
    else $error("tick finished without a final result");
`endif

endmodule

// ===== src/heartbeat_failure_voter.sv =====
// Top level of the heartbeat failure voter: controller plus datapath.
// Depends on hfv_pkg, hfv_ctrl and hfv_datapath.
//
// Usage:
//   Input: drive in_command/in_opcode/in_source_id/in_subject_id and raise
//   start; the transaction is taken at the clock edge where start is high
//   and busy is low. busy stays high while it is being worked on.
//   Results: each appears for one cycle with out_strobe high; out_last marks
//   the final result of a transaction. The receiver cannot stall, so every
//   strobe must be captured on the cycle it appears.
//   Configuration: cfg_we/cfg_index/cfg_data write my_id (0), node_count (1)
//   or miss_limit (2); write only while busy is low and no result is still
//   due. Writing my_id clears the new own entry.
// Sequence (n = min(node_count, 16)):
//   Message: busy while the message executes; its single result shows in the
//   next cycle. Tick: one pass over the n entries counts live nodes over the
//   single table read port, a second pass ages each entry and raises vote
//   requests, then a final step clears the own entry. Results trail by one
//   slot, the last one in the cycle in which busy falls.
// Reset (synchronous, rst_n low): all entries unmonitored except node 0,
//   which is this node's reset id; no votes open; registers at defaults.
module heartbeat_failure_voter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_command,
  input  logic [hfv_pkg::OP_W-1:0]       in_opcode,
  input  logic [hfv_pkg::ID_W-1:0]       in_source_id,
  input  logic [hfv_pkg::ID_W-1:0]       in_subject_id,
  output logic                           out_strobe,
  output logic [hfv_pkg::KIND_W-1:0]     out_kind,
  output logic [hfv_pkg::ID_W-1:0]       out_node_id,
  output logic [hfv_pkg::VOTES_W-1:0]    out_votes_needed,
  output logic                           out_last,
  input  logic                           cfg_we,
  input  logic [hfv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hfv_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hfv_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // Sequence the passes and hand out table indexes.
  hfv_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy)
  );

  // Hold the node table and configuration, form each result.
  hfv_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_opcode        (in_opcode),
    .in_source_id     (in_source_id),
    .in_subject_id    (in_subject_id),
    .out_strobe       (out_strobe),
    .out_kind         (out_kind),
    .out_node_id      (out_node_id),
    .out_votes_needed (out_votes_needed),
    .out_last         (out_last)
  );

endmodule
